// ===== design/fpwm_pkg.sv =====
// Shared types, constants and tables for the fan PWM temperature control unit.
package fpwm_pkg;

    // Widths of the data path
    localparam int TEMP_W  = 8;
    localparam int PEAK_W  = 7;
    localparam int RPM_W   = 16;
    localparam int PWM_W   = 8;
    localparam int SUM_W   = 15;
    localparam int POS_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Divider: one quotient bit per step, one step per dividend bit
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Control thresholds
    localparam logic [SUM_W-1:0] COOL_LIMIT = SUM_W'(35);
    localparam logic [SUM_W-1:0] HOT_LIMIT  = SUM_W'(55);
    localparam logic [SUM_W-1:0] MOVE_MIN   = SUM_W'(2);

    // Register reset values and the fan drive maximum
    localparam logic [PWM_W-1:0] RST_PWM_FLOOR   = 8'd32;
    localparam logic [PWM_W-1:0] RST_PWM_CEILING = 8'd160;
    localparam logic [POS_W-1:0] RST_WINDOW_LEN  = 8'd1;
    localparam logic [7:0]       RST_TACH_SCALE  = 8'd120;
    localparam logic [PWM_W-1:0] PWM_MAX         = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TACH_SCALE  = 3'd3;

    // Input beat: one status report
    typedef struct packed {
        logic [7:0] raw_temp_a;
        logic [7:0] raw_temp_b;
        logic [7:0] raw_temp_c;
        logic [7:0] raw_fan_a;
        logic [7:0] raw_fan_b;
        logic [7:0] raw_fan_c;
    } t_report_in;

    // Output beat: decoded report plus control result
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_a;
        logic signed [TEMP_W-1:0] temp_b;
        logic signed [TEMP_W-1:0] temp_c;
        logic [RPM_W-1:0]         fan_rpm_a;
        logic [RPM_W-1:0]         fan_rpm_b;
        logic [RPM_W-1:0]         fan_rpm_c;
        logic [PEAK_W-1:0]        hottest_seen;
        logic [PWM_W-1:0]         fan_drive;
    } t_report_out;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // Raise a peak by one temperature byte; negative readings never count
    function automatic logic [PEAK_W-1:0] raise_peak(input logic [PEAK_W-1:0] peak,
                                                     input logic [TEMP_W-1:0] raw);
        logic [PEAK_W-1:0] res;
        res = peak;
        if (!raw[TEMP_W-1] && (raw[PEAK_W-1:0] > peak)) begin
            res = raw[PEAK_W-1:0];
        end
        return res;
    endfunction

    // Ramp step floor(d * 6.4) for d = avg - 35 over the linear band
    function automatic logic [PWM_W-1:0] ramp_step(input logic [4:0] d);
        logic [PWM_W-1:0] res;
        case (d)
            5'd0:    res = 8'd0;
            5'd1:    res = 8'd6;
            5'd2:    res = 8'd12;
            5'd3:    res = 8'd19;
            5'd4:    res = 8'd25;
            5'd5:    res = 8'd32;
            5'd6:    res = 8'd38;
            5'd7:    res = 8'd44;
            5'd8:    res = 8'd51;
            5'd9:    res = 8'd57;
            5'd10:   res = 8'd64;
            5'd11:   res = 8'd70;
            5'd12:   res = 8'd76;
            5'd13:   res = 8'd83;
            5'd14:   res = 8'd89;
            5'd15:   res = 8'd96;
            5'd16:   res = 8'd102;
            5'd17:   res = 8'd108;
            5'd18:   res = 8'd115;
            5'd19:   res = 8'd121;
            5'd20:   res = 8'd128;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/fpwm_div.sv =====
// Iterative restoring divider: window sum over window length, one bit per cycle.
module fpwm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpwm_pkg::t_div_req  i_req,
    output fpwm_pkg::t_div_rsp  o_rsp
);

    logic [fpwm_pkg::SUM_W-1:0]     r_quo, n_quo;
    logic [fpwm_pkg::POS_W-1:0]     r_rem, n_rem;
    logic [fpwm_pkg::POS_W-1:0]     r_den, n_den;
    logic [fpwm_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;

    logic [fpwm_pkg::POS_W:0]       rem_sh;
    logic [fpwm_pkg::POS_W:0]       rem_sub;
    logic                           fits;

    // Shared compare and subtract of one step
    always_comb begin
        rem_sh  = {r_rem, r_quo[fpwm_pkg::SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // Load on start, then shift one quotient bit in per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[fpwm_pkg::SUM_W-2:0], fits};
            n_rem = fits ? rem_sub[fpwm_pkg::POS_W-1:0] : rem_sh[fpwm_pkg::POS_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == fpwm_pkg::DIV_CNT_W'(fpwm_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== design/fan_pwm_temperature_control_unit.sv =====
// Top level of the fan PWM temperature control unit: sequencer, state and output register.
// A report that does not close a window moves from the idle step to the output step; one that
//   closes a window passes through the division step (one-bit-per-cycle divider) and the
//   decision step first. A new report is taken only in the idle step, after the last one has
//   moved to the output register. A new report is taken while the last result waits.
// Reset (synchronous, active low) restores register defaults and clears peak, window and
//   average state; fan drive returns to 32.
module fan_pwm_temperature_control_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fpwm_pkg::t_report_in             i_report,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fpwm_pkg::t_report_out            o_result,
    input  logic                             i_cfg_we,
    input  logic [fpwm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpwm_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [fpwm_pkg::PWM_W-1:0] r_pwm_floor;
    logic [fpwm_pkg::PWM_W-1:0] r_pwm_ceiling;
    logic [fpwm_pkg::POS_W-1:0] r_window_len;
    logic [7:0]                 r_tach_scale;

    // Control state
    fpwm_pkg::t_state           r_state, n_state;
    logic [fpwm_pkg::PEAK_W-1:0] r_peak, n_peak;
    logic [fpwm_pkg::SUM_W-1:0] r_window_sum, n_window_sum;
    logic [fpwm_pkg::POS_W-1:0] r_window_pos, n_window_pos;
    logic [fpwm_pkg::SUM_W-1:0] r_last_avg, n_last_avg;
    logic [fpwm_pkg::PWM_W-1:0] r_drive_level, n_drive_level;
    logic                       r_out_valid;

    // Payload
    fpwm_pkg::t_report_out      r_stage, n_stage;
    fpwm_pkg::t_report_out      r_out, n_out;

    // Divider link
    fpwm_pkg::t_div_req         div_req;
    fpwm_pkg::t_div_rsp         div_rsp;

    // Sequencer controls
    logic                       in_beat;
    logic                       out_free;
    logic                       load_out;
    logic                       do_decide;

    // Per-report working values
    logic [fpwm_pkg::POS_W-1:0] win_len;
    logic [fpwm_pkg::POS_W-1:0] pos_inc;
    logic [fpwm_pkg::SUM_W-1:0] sum_inc;
    logic                       win_close;

    // Decision values
    logic [fpwm_pkg::SUM_W-1:0] avg;
    logic [fpwm_pkg::SUM_W-1:0] avg_diff;
    logic [4:0]                 ramp_idx;
    logic [fpwm_pkg::PWM_W:0]   ramp_sum;
    logic [fpwm_pkg::PWM_W-1:0] ramp_pwm;

    fpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Handshake terms
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_beat  = i_in_valid && (r_state == fpwm_pkg::ST_IDLE);

    // Decode one report, advance peak and window
    always_comb begin
        win_len = (r_window_len == '0) ? fpwm_pkg::POS_W'(1) : r_window_len;
        n_peak  = fpwm_pkg::raise_peak(r_peak, i_report.raw_temp_a);
        n_peak  = fpwm_pkg::raise_peak(n_peak, i_report.raw_temp_b);
        n_peak  = fpwm_pkg::raise_peak(n_peak, i_report.raw_temp_c);
        pos_inc = r_window_pos + 1'b1;
        sum_inc = r_window_sum + fpwm_pkg::SUM_W'(n_peak);
        win_close = (pos_inc >= win_len) || (pos_inc == '0);

        n_stage.temp_a       = i_report.raw_temp_a;
        n_stage.temp_b       = i_report.raw_temp_b;
        n_stage.temp_c       = i_report.raw_temp_c;
        n_stage.fan_rpm_a    = fpwm_pkg::RPM_W'(i_report.raw_fan_a)
                             * fpwm_pkg::RPM_W'(r_tach_scale);
        n_stage.fan_rpm_b    = fpwm_pkg::RPM_W'(i_report.raw_fan_b)
                             * fpwm_pkg::RPM_W'(r_tach_scale);
        n_stage.fan_rpm_c    = fpwm_pkg::RPM_W'(i_report.raw_fan_c)
                             * fpwm_pkg::RPM_W'(r_tach_scale);
        n_stage.hottest_seen = n_peak;
        n_stage.fan_drive    = r_drive_level;

        n_window_pos = win_close ? '0 : pos_inc;
        n_window_sum = win_close ? '0 : sum_inc;
    end

    // Close the window: pick floor, ceiling or ramp from the average, or keep the drive if it moved by under 2
    always_comb begin
        avg      = div_rsp.quotient;
        avg_diff = (avg >= r_last_avg) ? (avg - r_last_avg) : (r_last_avg - avg);
        ramp_idx = 5'(avg - fpwm_pkg::COOL_LIMIT);
        ramp_sum = {1'b0, r_pwm_floor} + {1'b0, fpwm_pkg::ramp_step(ramp_idx)};
        ramp_pwm = ramp_sum[fpwm_pkg::PWM_W] ? fpwm_pkg::PWM_MAX
                                              : ramp_sum[fpwm_pkg::PWM_W-1:0];
        n_drive_level = r_drive_level;
        n_last_avg    = r_last_avg;
        if (do_decide) begin
            if (avg < fpwm_pkg::COOL_LIMIT) begin
                n_drive_level = r_pwm_floor;
                n_last_avg    = avg;
            end else if (avg > fpwm_pkg::HOT_LIMIT) begin
                n_drive_level = r_pwm_ceiling;
                n_last_avg    = avg;
            end else if (avg_diff >= fpwm_pkg::MOVE_MIN) begin
                n_drive_level = ramp_pwm;
                n_last_avg    = avg;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpwm_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = win_close ? fpwm_pkg::ST_DIV : fpwm_pkg::ST_OUT;
                end
            end
            fpwm_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = fpwm_pkg::ST_DECIDE;
                end
            end
            fpwm_pkg::ST_DECIDE: begin
                n_state = fpwm_pkg::ST_OUT;
            end
            fpwm_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = fpwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall       = 1'b1;
        div_req.start    = 1'b0;
        div_req.dividend = sum_inc;
        div_req.divisor  = win_len;
        do_decide        = 1'b0;
        load_out         = 1'b0;
        case (r_state)
            fpwm_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                div_req.start = in_beat && win_close;
            end
            fpwm_pkg::ST_DIV: begin
            end
            fpwm_pkg::ST_DECIDE: begin
                do_decide = 1'b1;
            end
            fpwm_pkg::ST_OUT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes; indexes beyond the list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_floor   <= fpwm_pkg::RST_PWM_FLOOR;
            r_pwm_ceiling <= fpwm_pkg::RST_PWM_CEILING;
            r_window_len  <= fpwm_pkg::RST_WINDOW_LEN;
            r_tach_scale  <= fpwm_pkg::RST_TACH_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpwm_pkg::CFG_PWM_FLOOR:   r_pwm_floor   <= i_cfg_data;
                fpwm_pkg::CFG_PWM_CEILING: r_pwm_ceiling <= i_cfg_data;
                fpwm_pkg::CFG_WINDOW_LEN:  r_window_len  <= i_cfg_data;
                fpwm_pkg::CFG_TACH_SCALE:  r_tach_scale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fpwm_pkg::ST_IDLE;
            r_peak        <= '0;
            r_window_sum  <= '0;
            r_window_pos  <= '0;
            r_last_avg    <= '0;
            r_drive_level <= fpwm_pkg::RST_PWM_FLOOR;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_last_avg    <= n_last_avg;
            r_drive_level <= n_drive_level;
            if (in_beat) begin
                r_peak       <= n_peak;
                r_window_sum <= n_window_sum;
                r_window_pos <= n_window_pos;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Refresh the fan drive of the staged report with the decided level
    always_comb begin
        n_out           = r_stage;
        n_out.fan_drive = r_drive_level;
    end

    // Hold the report in the stage, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_stage <= n_stage;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // The divider is never restarted while a division runs
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A report that leaves the window open goes straight to the output step
    a_open_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !win_close) |=> (r_state == fpwm_pkg::ST_OUT))
        else $error("open-window report did not reach output step");

    // Fan drive changes only in the decision step
    a_drive_only_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fpwm_pkg::ST_DECIDE) |=> $stable(r_drive_level))
        else $error("fan drive changed outside decision step");

    // The division result is consumed only after the divider signals done
    a_decide_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpwm_pkg::ST_DIV && !div_rsp.done) |=> (r_state == fpwm_pkg::ST_DIV))
        else $error("left division step before quotient was ready");

endmodule
